[rtl/mams_pkg.sv]
// Shared types and constants for the motor arming sequencer.
// Depends on nothing; the core in rtl/ refers to it by scoped names.
package mams_pkg;

	localparam int unsigned ThrottleWidth = 16;
	localparam int unsigned ElapsedWidth  = 16;
	localparam int unsigned TimeoutWidth  = 24;
	localparam int unsigned TimerWidth    = 25;
	localparam int unsigned CfgIndexWidth = 2;
	localparam int unsigned CfgDataWidth  = 24;

	localparam logic [ThrottleWidth-1:0] StartThresholdReset = 16'd6554;
	localparam logic [ThrottleWidth-1:0] StopThresholdReset  = 16'd3277;
	// 4.0 seconds expressed in microseconds.
	localparam logic [TimeoutWidth-1:0]  SpinTimeoutReset    = 24'd4000000;

	typedef enum logic [2:0] {
		MODE_SAFETY   = 3'd0,
		MODE_HALTED   = 3'd1,
		MODE_STOPPING = 3'd2,
		MODE_STARTING = 3'd3,
		MODE_SPINNING = 3'd4,
		MODE_FLYING   = 3'd5
	} mode_t;

	typedef enum logic [1:0] {
		FLIGHT_STANDING = 2'd0,
		FLIGHT_FLYING   = 2'd1,
		FLIGHT_OTHER    = 2'd2,
		FLIGHT_UNKNOWN  = 2'd3
	} flight_t;

	typedef enum logic [CfgIndexWidth-1:0] {
		REG_START_THRESHOLD = 2'd0,
		REG_STOP_THRESHOLD  = 2'd1,
		REG_SPIN_TIMEOUT    = 2'd2,
		REG_UNUSED          = 2'd3
	} reg_index_t;

	typedef struct packed {
		logic                     lock_request;
		logic [ThrottleWidth-1:0] throttle;
		logic [1:0]               flight_status;
		logic                     start_permitted;
		logic [ElapsedWidth-1:0]  elapsed_us;
	} tick_t;

	typedef struct packed {
		logic [2:0] motor_state;
		logic       is_safe;
		logic       is_spinning;
		logic       is_controllable;
	} status_t;

	typedef struct packed {
		logic [CfgIndexWidth-1:0] index;
		logic [CfgDataWidth-1:0]  data;
	} cfg_write_t;

endpackage

[rtl/mams_stream_if.sv]
// Valid/ready channel carrying one payload word per handshake.
// Depends on nothing; the payload type is given by the instantiating scope.
interface mams_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

[rtl/motor_arming_state_machine_core.sv]
// Top level of the motor arming sequencer.
// Depends on mams_pkg and on the mams_stream_if channel interface.

// The sequencer takes one control tick per word on the tick channel and returns one
// status word per tick on the result channel, in order, with the motor state after
// that tick and the safe, spinning and controllable flags. A tick is captured in an
// input register; in the cycle it moves on, a short block of compare and add logic
// updates the motor state and the spin timer and loads the result register. A new
// tick can be accepted every cycle while the result side keeps taking words; a result
// that waits to be taken lets one more tick into the input register, after which the
// tick channel stalls until the result is taken.
// Throttle and thresholds are unsigned 16-bit fractions of full scale, and time is
// in whole microseconds. The three registers (start threshold, stop threshold and
// spin timeout) are written on the cfg channel, which is always ready; they should
// only be changed while no tick is in flight. Writes to an unused index are ignored.

module motor_arming_state_machine_core (
	input  logic           clk,
	input  logic           arst_n,
	mams_stream_if.sink    tick,
	mams_stream_if.source  result,
	mams_stream_if.sink    cfg
);

	// Configuration registers.
	logic [mams_pkg::ThrottleWidth-1:0] start_threshold_q;
	logic [mams_pkg::ThrottleWidth-1:0] stop_threshold_q;
	logic [mams_pkg::TimeoutWidth-1:0]  spin_timeout_q;

	// Sequencer state.
	mams_pkg::mode_t                    mode_q;
	logic [mams_pkg::TimerWidth-1:0]    spin_elapsed_q;

	// Input stage and result stage.
	logic                               valid_s1;
	mams_pkg::tick_t                    tick_s1;
	logic                               valid_s2;
	mams_pkg::status_t                  status_s2;

	logic                               advance;
	mams_pkg::mode_t                    mode_next;
	logic [mams_pkg::TimerWidth-1:0]    spin_elapsed_next;
	mams_pkg::status_t                  status_next;

	logic                               want_start;
	logic                               want_stop;
	logic [mams_pkg::TimerWidth:0]      timer_sum;
	logic                               timer_fires;
	logic [mams_pkg::TimerWidth-1:0]    timer_held;

	// The configuration channel never stalls.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_threshold_q <= mams_pkg::StartThresholdReset;
			stop_threshold_q  <= mams_pkg::StopThresholdReset;
			spin_timeout_q    <= mams_pkg::SpinTimeoutReset;
		end else if (cfg.valid) begin
			case (mams_pkg::reg_index_t'(cfg.payload.index))
				mams_pkg::REG_START_THRESHOLD: begin
					start_threshold_q <= cfg.payload.data[mams_pkg::ThrottleWidth-1:0];
				end
				mams_pkg::REG_STOP_THRESHOLD: begin
					stop_threshold_q <= cfg.payload.data[mams_pkg::ThrottleWidth-1:0];
				end
				mams_pkg::REG_SPIN_TIMEOUT: begin
					spin_timeout_q <= cfg.payload.data[mams_pkg::TimeoutWidth-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// The input stage moves on whenever the result register is empty or being
	// emptied in this cycle. A new tick is captured when the input stage is empty
	// or moving on, so a waiting result blocks the tick channel only once the
	// input stage is also full.
	assign advance     = valid_s1 && (!valid_s2 || result.ready);
	assign tick.ready  = !valid_s1 || advance;

	// Start and stop requests use strict comparisons against the thresholds.
	assign want_start = (tick_s1.throttle > start_threshold_q) && tick_s1.start_permitted;
	assign want_stop  = tick_s1.throttle < stop_threshold_q;

	// The spin timer adds the tick's elapsed time and saturates at the timeout.
	// A timeout lowered below the running count fires at the next check.
	assign timer_sum   = {1'b0, spin_elapsed_q}
		+ {{(mams_pkg::TimerWidth + 1 - mams_pkg::ElapsedWidth){1'b0}}, tick_s1.elapsed_us};
	assign timer_fires = timer_sum
		>= {{(mams_pkg::TimerWidth + 1 - mams_pkg::TimeoutWidth){1'b0}}, spin_timeout_q};
	assign timer_held  = timer_fires
		? {{(mams_pkg::TimerWidth - mams_pkg::TimeoutWidth){1'b0}}, spin_timeout_q}
		: timer_sum[mams_pkg::TimerWidth-1:0];

	// Next state of the sequencer for the tick held in the input stage.
	always_comb begin
		mode_next         = mode_q;
		spin_elapsed_next = spin_elapsed_q;
		case (mode_q)
			mams_pkg::MODE_SAFETY: begin
				if (!tick_s1.lock_request) begin
					mode_next = mams_pkg::MODE_HALTED;
				end
			end
			mams_pkg::MODE_FLYING: begin
				if (tick_s1.flight_status == mams_pkg::FLIGHT_STANDING) begin
					mode_next = mams_pkg::MODE_SPINNING;
				end
			end
			mams_pkg::MODE_HALTED: begin
				if (tick_s1.lock_request) begin
					mode_next = mams_pkg::MODE_SAFETY;
				end else if (want_start) begin
					mode_next         = mams_pkg::MODE_STARTING;
					spin_elapsed_next = '0;
				end
			end
			mams_pkg::MODE_STARTING: begin
				if (want_stop) begin
					mode_next         = mams_pkg::MODE_STOPPING;
					spin_elapsed_next = '0;
				end else begin
					spin_elapsed_next = timer_held;
					if (timer_fires) begin
						mode_next = mams_pkg::MODE_SPINNING;
					end
				end
			end
			mams_pkg::MODE_SPINNING: begin
				if (want_stop) begin
					mode_next         = mams_pkg::MODE_STOPPING;
					spin_elapsed_next = '0;
				end else if (tick_s1.flight_status == mams_pkg::FLIGHT_FLYING) begin
					mode_next = mams_pkg::MODE_FLYING;
				end
			end
			mams_pkg::MODE_STOPPING: begin
				if (want_start) begin
					mode_next         = mams_pkg::MODE_STARTING;
					spin_elapsed_next = '0;
				end else if (timer_fires) begin
					// Spin-down done: halt and clear the timer.
					mode_next         = mams_pkg::MODE_HALTED;
					spin_elapsed_next = '0;
				end else begin
					spin_elapsed_next = timer_held;
				end
			end
			default: begin
				mode_next = mams_pkg::MODE_SAFETY;
			end
		endcase

		status_next.motor_state     = mode_next;
		status_next.is_safe         = (mode_next == mams_pkg::MODE_SAFETY);
		status_next.is_spinning     = (mode_next == mams_pkg::MODE_STARTING)
			|| (mode_next == mams_pkg::MODE_SPINNING)
			|| (mode_next == mams_pkg::MODE_FLYING);
		status_next.is_controllable = (mode_next == mams_pkg::MODE_SPINNING)
			|| (mode_next == mams_pkg::MODE_FLYING);
	end

	// Sequencer state only changes when a tick leaves the input stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q         <= mams_pkg::MODE_SAFETY;
			spin_elapsed_q <= '0;
		end else if (advance) begin
			mode_q         <= mode_next;
			spin_elapsed_q <= spin_elapsed_next;
		end
	end

	// Input stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (tick.ready) begin
			valid_s1 <= tick.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (tick.valid && tick.ready) begin
			tick_s1 <= tick.payload;
		end
	end

	// Result stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (result.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			status_s2 <= status_next;
		end
	end

	assign result.valid   = valid_s2;
	assign result.payload = status_s2;

endmodule

[tb/sv/tb_motor_arming_state_machine_core.sv]
// Self-checking testbench for motor_arming_state_machine_core: directed and random ticks,
// a cycle-free predictor of the arming sequencer, and field-by-field result checking.
// Depends on mams_pkg and mams_stream_if from rtl/.
module tb_motor_arming_state_machine_core;
	timeunit 1ns;
	timeprecision 1ps;

	import mams_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	mams_stream_if #(.payload_t(tick_t))      tick_ch ();
	mams_stream_if #(.payload_t(status_t))    result_ch ();
	mams_stream_if #(.payload_t(cfg_write_t)) cfg_ch ();

	motor_arming_state_machine_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.tick   (tick_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	// Ticks and register writes wait here until the driver puts them on their channels.
	tick_t      pending_ticks[$];
	cfg_write_t pending_writes[$];
	// Status words the sequencer owes us, oldest first.
	status_t    expected_status[$];

	// Predictor copy of the sequencer: its registers and its state.
	logic [ThrottleWidth-1:0] start_level;
	logic [ThrottleWidth-1:0] stop_level;
	logic [TimeoutWidth-1:0]  spin_limit;
	mode_t                    motor_mode;
	logic [TimerWidth-1:0]    spin_time;

	int error_count = 0;
	int result_count = 0;
	int burst_left;
	int gap_left;
	logic [7:0] stall_pattern;
	int pattern_age;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Spin timer step: add the tick's elapsed time and report whether the spin timeout
	// has been reached. Once reached, the timer sits exactly at the timeout. A timeout
	// lowered below the running count therefore fires on the very next check.
	function automatic logic spin_timer_expired(logic [ElapsedWidth-1:0] dt);
		logic [TimerWidth:0] total;
		total = {1'b0, spin_time} + {{(TimerWidth + 1 - ElapsedWidth){1'b0}}, dt};
		if (total >= {{(TimerWidth + 1 - TimeoutWidth){1'b0}}, spin_limit}) begin
			spin_time = {{(TimerWidth - TimeoutWidth){1'b0}}, spin_limit};
			return 1'b1;
		end
		spin_time = total[TimerWidth-1:0];
		return 1'b0;
	endfunction

	// One control tick through the arming state machine; returns the status after it.
	function automatic status_t advance_sequencer(tick_t t);
		logic    want_start;
		logic    want_stop;
		status_t s;
		// Both thresholds are strict comparisons.
		want_start = (t.throttle > start_level) && t.start_permitted;
		want_stop  = t.throttle < stop_level;
		case (motor_mode)
			MODE_SAFETY: begin
				if (!t.lock_request)
					motor_mode = MODE_HALTED;
			end
			MODE_FLYING: begin
				// Only a clear "standing" report brings us back; other or unknown
				// status keeps us flying.
				if (t.flight_status == FLIGHT_STANDING)
					motor_mode = MODE_SPINNING;
			end
			MODE_HALTED: begin
				if (t.lock_request) begin
					motor_mode = MODE_SAFETY;
				end else if (want_start) begin
					motor_mode = MODE_STARTING;
					spin_time  = '0;
				end
			end
			MODE_STARTING: begin
				if (want_stop) begin
					motor_mode = MODE_STOPPING;
					spin_time  = '0;
				end else if (spin_timer_expired(t.elapsed_us)) begin
					motor_mode = MODE_SPINNING;
				end
			end
			MODE_SPINNING: begin
				if (want_stop) begin
					motor_mode = MODE_STOPPING;
					spin_time  = '0;
				end else if (t.flight_status == FLIGHT_FLYING) begin
					motor_mode = MODE_FLYING;
				end
			end
			MODE_STOPPING: begin
				if (want_start) begin
					motor_mode = MODE_STARTING;
					spin_time  = '0;
				end else if (spin_timer_expired(t.elapsed_us)) begin
					motor_mode = MODE_HALTED;
					spin_time  = '0;
				end
			end
			default: begin
				motor_mode = MODE_SAFETY;
			end
		endcase
		s.motor_state     = motor_mode;
		s.is_safe         = (motor_mode == MODE_SAFETY);
		s.is_spinning     = (motor_mode == MODE_STARTING) || (motor_mode == MODE_SPINNING) ||
			(motor_mode == MODE_FLYING);
		s.is_controllable = (motor_mode == MODE_SPINNING) || (motor_mode == MODE_FLYING);
		return s;
	endfunction

	// Register writes as the sequencer applies them; the unused index is ignored.
	function automatic void apply_register_write(cfg_write_t w);
		case (w.index)
			REG_START_THRESHOLD: start_level = w.data[ThrottleWidth-1:0];
			REG_STOP_THRESHOLD:  stop_level  = w.data[ThrottleWidth-1:0];
			REG_SPIN_TIMEOUT:    spin_limit  = w.data[TimeoutWidth-1:0];
			default: ;
		endcase
	endfunction

	// Driver for the tick and cfg channels. A word leaves only when the previous one was
	// taken, so valid never drops while a word is on offer. Ticks go out in bursts of
	// random length separated by random gaps; a fair share of gaps is zero so that
	// back-to-back stretches occur. The predictor runs here, at the edge where a word is
	// accepted, which keeps it in step with the sequencer's own view of the registers.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_ch.valid   <= 1'b0;
			tick_ch.payload <= '0;
			cfg_ch.valid    <= 1'b0;
			cfg_ch.payload  <= '0;
			burst_left      <= 1;
			gap_left        <= 0;
			start_level     = StartThresholdReset;
			stop_level      = StopThresholdReset;
			spin_limit      = SpinTimeoutReset;
			motor_mode      = MODE_SAFETY;
			spin_time       = '0;
		end else begin
			if (tick_ch.valid && tick_ch.ready)
				expected_status.push_back(advance_sequencer(tick_ch.payload));
			if (cfg_ch.valid && cfg_ch.ready)
				apply_register_write(cfg_ch.payload);

			if (!tick_ch.valid || tick_ch.ready) begin
				if (gap_left > 0) begin
					tick_ch.valid <= 1'b0;
					gap_left      <= gap_left - 1;
				end else if (pending_ticks.size() > 0) begin
					tick_ch.valid   <= 1'b1;
					tick_ch.payload <= pending_ticks.pop_front();
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(20, 1);
						gap_left   <= ($urandom_range(9, 0) < 4) ? 0 : $urandom_range(5, 1);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					tick_ch.valid <= 1'b0;
				end
			end

			if (!cfg_ch.valid || cfg_ch.ready) begin
				if (pending_writes.size() > 0) begin
					cfg_ch.valid   <= 1'b1;
					cfg_ch.payload <= pending_writes.pop_front();
				end else begin
					cfg_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Result side back-pressure: ready follows a rotating 8-bit pattern that is replaced
	// whenever its random age counter runs out. Some patterns are all ones (no stalls at all);
	// the others always keep one bit set, so every stall comes to an end.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
			stall_pattern   <= 8'hFF;
			pattern_age     <= 0;
		end else begin
			result_ch.ready <= stall_pattern[0];
			if (pattern_age == 0) begin
				stall_pattern <= ($urandom_range(3, 0) == 0) ? 8'hFF : (8'($urandom()) | 8'h01);
				pattern_age   <= $urandom_range(64, 16);
			end else begin
				stall_pattern <= {stall_pattern[0], stall_pattern[7:1]};
				pattern_age   <= pattern_age - 1;
			end
		end
	end

	// Monitor: every accepted status word is matched against the oldest prediction.
	always @(posedge clk) begin
		status_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			result_count <= result_count + 1;
			if (expected_status.size() == 0) begin
				error_count <= error_count + 1;
				if (error_count < 10)
					$display("word %0d arrived with nothing expected: state %0d flags %b%b%b",
						result_count, result_ch.payload.motor_state, result_ch.payload.is_safe,
						result_ch.payload.is_spinning, result_ch.payload.is_controllable);
			end else begin
				want = expected_status.pop_front();
				if ((result_ch.payload.motor_state !== want.motor_state) ||
					(result_ch.payload.is_safe !== want.is_safe) ||
					(result_ch.payload.is_spinning !== want.is_spinning) ||
					(result_ch.payload.is_controllable !== want.is_controllable)) begin
					error_count <= error_count + 1;
					if (error_count < 10)
						$display("word %0d mismatch: expected state %0d safe %b spin %b ctrl %b, %s",
							result_count, want.motor_state, want.is_safe, want.is_spinning,
							want.is_controllable,
							$sformatf("got state %0d safe %b spin %b ctrl %b",
								result_ch.payload.motor_state, result_ch.payload.is_safe,
								result_ch.payload.is_spinning,
								result_ch.payload.is_controllable));
				end
			end
		end
	end

	// Waits until every queued word has been taken and every status word has come back.
	task automatic settle();
		do
			@(negedge clk);
		while (pending_ticks.size() != 0 || tick_ch.valid || pending_writes.size() != 0 ||
			cfg_ch.valid || expected_status.size() != 0);
		repeat (8) @(negedge clk);
	endtask

	// Register writes only happen with the sequencer idle.
	task automatic write_reg(reg_index_t idx, logic [CfgDataWidth-1:0] value);
		cfg_write_t w;
		settle();
		w.index = idx;
		w.data  = value;
		pending_writes.push_back(w);
		settle();
	endtask

	task automatic send_tick(logic lock, logic [ThrottleWidth-1:0] thr, logic [1:0] fs,
		logic perm, logic [ElapsedWidth-1:0] dt);
		tick_t t;
		t.lock_request    = lock;
		t.throttle        = thr;
		t.flight_status   = fs;
		t.start_permitted = perm;
		t.elapsed_us      = dt;
		pending_ticks.push_back(t);
	endtask

	// One random phase under a given register setting. Ticks come in runs that share a
	// throttle band, a flight status and the start permission, so the machine actually
	// walks through start-up, flight, landing and spin-down. About one tick in ten is
	// pure noise across the full range of every field.
	task automatic random_phase(logic [ThrottleWidth-1:0] start_thr,
		logic [ThrottleWidth-1:0] stop_thr, logic [TimeoutWidth-1:0] timeout, int count);
		int run_left;
		int band;
		int dt_pick;
		logic [1:0] run_fs;
		logic run_perm;
		logic run_lock;
		logic lock;
		logic [ThrottleWidth-1:0] thr;
		logic [1:0] fs;
		logic [ElapsedWidth-1:0] dt;
		write_reg(REG_START_THRESHOLD, CfgDataWidth'(start_thr));
		write_reg(REG_STOP_THRESHOLD, CfgDataWidth'(stop_thr));
		write_reg(REG_SPIN_TIMEOUT, timeout);
		run_left = 0;
		for (int i = 0; i < count; i++) begin
			if (run_left == 0) begin
				run_left = $urandom_range(12, 3);
				band     = $urandom_range(3, 0);
				run_fs   = 2'($urandom_range(3, 0));
				run_perm = ($urandom_range(3, 0) != 0);
				run_lock = ($urandom_range(6, 0) == 0);
			end
			run_left--;

			if ($urandom_range(9, 0) == 0) begin
				send_tick(1'($urandom_range(1, 0)), 16'($urandom_range(65535, 0)),
					2'($urandom_range(3, 0)), 1'($urandom_range(1, 0)),
					16'($urandom_range(65535, 0)));
			end else begin
				lock = run_lock || ($urandom_range(31, 0) == 0);
				case (band)
					0: thr = (stop_thr == 0) ? '0 : 16'($urandom_range(stop_thr - 1, 0));
					1: thr = 16'($urandom_range(stop_thr, start_thr));
					2: thr = (start_thr == 16'hFFFF) ? 16'hFFFF
						: 16'($urandom_range(65535, start_thr + 1));
					default: thr = 16'($urandom_range(65535, 0));
				endcase
				if ($urandom_range(19, 0) == 0)
					thr = $urandom_range(1, 0) ? 16'hFFFF : 16'h0000;
				fs = ($urandom_range(4, 0) == 0) ? 2'($urandom_range(3, 0)) : run_fs;
				dt_pick = $urandom_range(9, 0);
				if (dt_pick < 6)
					dt = 16'($urandom_range(65535, 0));
				else if (dt_pick < 8)
					dt = 16'($urandom_range(255, 0));
				else if (dt_pick == 8)
					dt = '0;
				else
					dt = 16'hFFFF;
				send_tick(lock, thr, fs, run_perm, dt);
			end
		end
	endtask

	initial begin
		// Known values on every input until the driver takes over at the first edge.
		tick_ch.valid     = 1'b0;
		tick_ch.payload   = '0;
		cfg_ch.valid      = 1'b0;
		cfg_ch.payload    = '0;
		result_ch.ready   = 1'b0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		// Walk the lock and the start conditions with the reset register values.
		send_tick(1'b1, 16'h0000, FLIGHT_STANDING, 1'b0, 16'h0000);
		send_tick(1'b0, 16'h0000, FLIGHT_STANDING, 1'b0, 16'h0000);
		send_tick(1'b1, 16'hFFFF, FLIGHT_FLYING, 1'b1, 16'hFFFF);
		send_tick(1'b0, 16'hFFFF, FLIGHT_FLYING, 1'b1, 16'hFFFF);
		// Throttle equal to the start threshold does not start; above it without
		// permission does not either.
		send_tick(1'b0, 16'd6554, FLIGHT_STANDING, 1'b1, 16'd100);
		send_tick(1'b0, 16'd6555, FLIGHT_STANDING, 1'b0, 16'd100);
		send_tick(1'b0, 16'hFFFF, FLIGHT_OTHER, 1'b1, 16'hFFFF);
		// Throttle equal to the stop threshold keeps starting; the lock is ignored here.
		send_tick(1'b0, 16'd3277, FLIGHT_UNKNOWN, 1'b0, 16'hFFFF);
		send_tick(1'b1, 16'd3276, FLIGHT_FLYING, 1'b0, 16'h0000);
		send_tick(1'b0, 16'd6555, FLIGHT_STANDING, 1'b1, 16'h0000);
		send_tick(1'b0, 16'd20000, FLIGHT_STANDING, 1'b0, 16'd60000);

		// Shorter timeout, then lower it below what the timer already holds.
		write_reg(REG_SPIN_TIMEOUT, 24'd100000);
		send_tick(1'b0, 16'd20000, FLIGHT_STANDING, 1'b0, 16'd39999);
		write_reg(REG_SPIN_TIMEOUT, 24'd50000);
		send_tick(1'b0, 16'd20000, FLIGHT_STANDING, 1'b0, 16'h0000);
		send_tick(1'b0, 16'd20000, FLIGHT_UNKNOWN, 1'b0, 16'h0000);
		send_tick(1'b0, 16'd20000, FLIGHT_FLYING, 1'b0, 16'h0000);
		// While flying, the lock, a low throttle and other status change nothing.
		send_tick(1'b1, 16'h0000, FLIGHT_OTHER, 1'b0, 16'h0000);
		send_tick(1'b0, 16'd20000, FLIGHT_STANDING, 1'b0, 16'h0000);
		// Spin down with the timer landing exactly on the timeout.
		send_tick(1'b0, 16'h0000, FLIGHT_STANDING, 1'b0, 16'h0000);
		send_tick(1'b0, 16'h0000, FLIGHT_STANDING, 1'b0, 16'd49999);
		send_tick(1'b0, 16'h0000, FLIGHT_STANDING, 1'b0, 16'd1);
		send_tick(1'b0, 16'hFFFF, FLIGHT_STANDING, 1'b1, 16'h0000);

		// A zero timeout makes every timer check fire at once, even with no time passed.
		write_reg(REG_SPIN_TIMEOUT, 24'd0);
		send_tick(1'b0, 16'd20000, FLIGHT_STANDING, 1'b0, 16'h0000);
		send_tick(1'b0, 16'h0000, FLIGHT_STANDING, 1'b0, 16'h0000);
		send_tick(1'b0, 16'h0000, FLIGHT_STANDING, 1'b0, 16'h0000);

		// Writes to the unused index must leave all registers alone; full-scale start
		// threshold can never be exceeded.
		write_reg(REG_UNUSED, 24'hFFFFFF);
		write_reg(REG_START_THRESHOLD, 24'h00FFFF);
		send_tick(1'b0, 16'hFFFF, FLIGHT_STANDING, 1'b1, 16'hFFFF);
		// Zero thresholds: throttle zero cannot start, nothing can ever be below zero.
		write_reg(REG_START_THRESHOLD, 24'd0);
		write_reg(REG_STOP_THRESHOLD, 24'd0);
		send_tick(1'b0, 16'h0000, FLIGHT_STANDING, 1'b1, 16'h0000);
		send_tick(1'b0, 16'd1, FLIGHT_STANDING, 1'b1, 16'h0000);
		send_tick(1'b0, 16'h0000, FLIGHT_STANDING, 1'b0, 16'hFFFF);
		// Full-scale stop threshold: anything short of full scale stops.
		write_reg(REG_STOP_THRESHOLD, 24'h00FFFF);
		send_tick(1'b0, 16'hFFFF, FLIGHT_STANDING, 1'b0, 16'h0000);
		send_tick(1'b0, 16'hFFFE, FLIGHT_STANDING, 1'b0, 16'h0000);

		// Random phases across a range of settings, extremes included. Most timeouts are
		// a handful of ticks long so that full start and stop cycles happen often.
		random_phase(16'd30000, 16'd10000, 24'd200000, 130);
		random_phase(16'd0, 16'd0, 24'd1, 70);
		random_phase(16'd40000, 16'd50000, 24'd300000, 100);
		random_phase(16'hFFFF, 16'hFFFF, 24'hFFFFFF, 50);
		random_phase(16'd6554, 16'd3277, 24'd1000000, 120);
		random_phase(16'd20000, 16'd20000, 24'd0, 60);
		random_phase(16'd12000, 16'd4000, 24'd150000, 100);
		settle();

		if (error_count == 0 && expected_status.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// Watchdog: the slowest correct run is well under a tenth of this.
	initial begin
		#2_000_000;
		$display("status: fail");
		$finish;
	end

endmodule
